[design/cube_map_normal_texel_defines.svh]
// assertion macros shared by the checker
`ifndef CUBE_MAP_NORMAL_TEXEL_DEFINES_SVH
`define CUBE_MAP_NORMAL_TEXEL_DEFINES_SVH

// checked only out of reset
`define CMNT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cube map texel check failed");

// checked on every edge, reset included
`define CMNT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cube map texel reset check failed");

`endif

[design/cmnt_pkg.sv]
`timescale 1ns / 1ps
package cmnt_pkg;

  localparam int unsigned FACE_W = 3;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned H_W    = 10;  // half face size, up to 512
  localparam int unsigned C_W    = 11;  // signed direction component
  localparam int unsigned SQ_W   = 20;  // component squared
  localparam int unsigned S_W    = 21;  // squared magnitude
  localparam int unsigned K_W    = 16;  // width of 255 squared
  localparam int unsigned R_W    = SQ_W + K_W;
  localparam int unsigned P_W    = K_W + S_W;
  localparam int unsigned NCOMP  = 3;

  localparam logic [K_W-1:0] K255SQ = 16'd65025;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [IDX_W-1:0]  column;
    logic [IDX_W-1:0]  row;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } out_t;

endpackage

[design/cmnt_dir.sv]
`timescale 1ns / 1ps
module cmnt_dir #(
  parameter int unsigned HALF = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  cmnt_pkg::in_t               item_i,
  output logic signed [cmnt_pkg::C_W-1:0] c_o [cmnt_pkg::NCOMP],
  output logic [cmnt_pkg::S_W-1:0]    s_o,
  output logic [cmnt_pkg::R_W-1:0]    r_o [cmnt_pkg::NCOMP]
);
  import cmnt_pkg::*;

  localparam logic signed [C_W-1:0] H = C_W'(HALF);

  logic signed [C_W-1:0] i_s, j_s;
  logic signed [C_W-1:0] c1_d [NCOMP];
  logic signed [C_W-1:0] c1_q [NCOMP], c2_q [NCOMP], c3_q [NCOMP];
  logic [SQ_W-1:0] sq2_q [NCOMP];
  logic [S_W-1:0]  s3_q;
  logic [R_W-1:0]  r3_q [NCOMP];
  logic signed [2*C_W-1:0] prod [NCOMP];

  assign i_s = $signed({{(C_W-IDX_W){1'b0}}, item_i.column});
  assign j_s = $signed({{(C_W-IDX_W){1'b0}}, item_i.row});

  always_comb begin
    case (item_i.face)
      FACE_PX: begin c1_d[0] = H;       c1_d[1] = H - j_s; c1_d[2] = H - i_s; end
      FACE_NX: begin c1_d[0] = -H;      c1_d[1] = H - j_s; c1_d[2] = i_s - H; end
      FACE_PY: begin c1_d[0] = i_s - H; c1_d[1] = H;       c1_d[2] = j_s - H; end
      FACE_NY: begin c1_d[0] = i_s - H; c1_d[1] = -H;      c1_d[2] = H - j_s; end
      FACE_PZ: begin c1_d[0] = i_s - H; c1_d[1] = H - j_s; c1_d[2] = H;       end
      FACE_NZ: begin c1_d[0] = H - i_s; c1_d[1] = H - j_s; c1_d[2] = -H;      end
      default: begin c1_d[0] = '0;      c1_d[1] = '0;      c1_d[2] = '0;      end
    endcase
  end

  for (genvar n = 0; n < NCOMP; n++) begin : g_comp
    assign prod[n] = c1_q[n] * c1_q[n];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c1_q[n]  <= c1_d[n];
        c2_q[n]  <= c1_q[n];
        sq2_q[n] <= prod[n][SQ_W-1:0];
        c3_q[n]  <= c2_q[n];
        r3_q[n]  <= {{K_W{1'b0}}, sq2_q[n]} * K255SQ;
      end
    end
    assign c_o[n] = c3_q[n];
    assign r_o[n] = r3_q[n];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= S_W'(sq2_q[0]) + S_W'(sq2_q[1]) + S_W'(sq2_q[2]);
    end
  end
  assign s_o = s3_q;

endmodule

[design/cmnt_enc.sv]
`timescale 1ns / 1ps
module cmnt_enc (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [cmnt_pkg::C_W-1:0] c_i,
  input  logic [cmnt_pkg::S_W-1:0]      s_i,
  input  logic [cmnt_pkg::R_W-1:0]      r_i,
  output logic [cmnt_pkg::CODE_W-1:0]   code_o
);
  import cmnt_pkg::*;

  // per bit: stage a squares the candidate offset, stage b compares
  logic [CODE_W-1:0] ba_q [CODE_W], cand_q [CODE_W], bb_q [CODE_W];
  logic [K_W-1:0]    d2_q [CODE_W];
  logic              dpos_q [CODE_W], cna_q [CODE_W], cnb_q [CODE_W];
  logic [S_W-1:0]    sa_q [CODE_W], sb_q [CODE_W];
  logic [R_W-1:0]    ra_q [CODE_W], rb_q [CODE_W];

  for (genvar t = 0; t < CODE_W; t++) begin : g_bit
    localparam logic [CODE_W-1:0] M = CODE_W'(1) << (CODE_W - 1 - t);
    logic [CODE_W-1:0] b_in, cand;
    logic [S_W-1:0]    s_in;
    logic [R_W-1:0]    r_in;
    logic              cn_in, fits;
    logic signed [CODE_W+1:0] d;
    logic signed [2*CODE_W+3:0] dd;
    logic [P_W-1:0]    p;

    if (t == 0) begin : g_first
      assign b_in  = '0;
      assign s_in  = s_i;
      assign r_in  = r_i;
      assign cn_in = c_i[C_W-1];
    end else begin : g_next
      assign b_in  = bb_q[t-1];
      assign s_in  = sb_q[t-1];
      assign r_in  = rb_q[t-1];
      assign cn_in = cnb_q[t-1];
    end

    assign cand = b_in | M;
    assign d    = $signed({1'b0, cand, 1'b0}) - (CODE_W+2)'(255);
    assign dd   = d * d;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ba_q[t]   <= b_in;
        cand_q[t] <= cand;
        d2_q[t]   <= dd[K_W-1:0];
        dpos_q[t] <= (d > 0);
        sa_q[t]   <= s_in;
        ra_q[t]   <= r_in;
        cna_q[t]  <= cn_in;
      end
    end

    assign p = d2_q[t] * sa_q[t];

    always_comb begin
      if (dpos_q[t]) fits = !cna_q[t] && (p <= P_W'(ra_q[t]));
      else           fits = !cna_q[t] || (p >= P_W'(ra_q[t]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bb_q[t]  <= fits ? cand_q[t] : ba_q[t];
        sb_q[t]  <= sa_q[t];
        rb_q[t]  <= ra_q[t];
        cnb_q[t] <= cna_q[t];
      end
    end
  end

  assign code_o = bb_q[CODE_W-1];

endmodule

[design/cube_map_normal_texel.sv]
`timescale 1ns / 1ps
// throughput: one texel per cycle unless a held result stalls the pipe; a
// 19-stage pipeline, three direction stages then two stages per code bit
// in each of three encoder lanes
// reset: rst_ni low clears all stage valid bits at once, data regs unreset
module cube_map_normal_texel #(
  parameter int unsigned FACE_SIZE = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cmnt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cmnt_pkg::out_t out_data_o
);
  import cmnt_pkg::*;

  localparam int unsigned HALF  = FACE_SIZE / 2;
  // three direction stages plus two per code bit
  localparam int unsigned NSTG  = 3 + 2 * CODE_W;

  logic              en;
  logic [NSTG-1:0]   vld_q, ok_q;
  logic signed [C_W-1:0] c [NCOMP];
  logic [S_W-1:0]    s;
  logic [R_W-1:0]    r [NCOMP];
  logic [CODE_W-1:0] code [NCOMP];

  // whole pipe advances unless the result register holds an untaken transfer
  assign en         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // face codes six and seven give an all-zero texel
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= {ok_q[NSTG-2:0], (in_data_i.face <= FACE_NZ)};
    end
  end

  cmnt_dir #(
    .HALF (HALF)
  ) u_dir (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (in_data_i),
    .c_o    (c),
    .s_o    (s),
    .r_o    (r)
  );

  // one encoder lane per color channel
  for (genvar n = 0; n < NCOMP; n++) begin : g_lane
    cmnt_enc u_enc (
      .clk_i  (clk_i),
      .en_i   (en),
      .c_i    (c[n]),
      .s_i    (s),
      .r_i    (r[n]),
      .code_o (code[n])
    );
  end

  assign out_valid_o      = vld_q[NSTG-1];
  assign out_data_o.red   = ok_q[NSTG-1] ? code[0] : '0;
  assign out_data_o.green = ok_q[NSTG-1] ? code[1] : '0;
  assign out_data_o.blue  = ok_q[NSTG-1] ? code[2] : '0;

endmodule

[design/cmnt_checker.sv]
`timescale 1ns / 1ps
`include "cube_map_normal_texel_defines.svh"
module cmnt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input cmnt_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cmnt_pkg::out_t out_data_o
);
  import cmnt_pkg::*;

  // a stalled result holds
  `CMNT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  // an empty result slot never blocks input
  `CMNT_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  // input stalls only behind a stalled result
  `CMNT_ASSERT(a_ready_stall, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i)
  // reset empties the pipe
  `CMNT_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind cube_map_normal_texel cmnt_checker u_cmnt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/tb_checker.sv]
`timescale 1ns / 1ps
module tb_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cmnt_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cmnt_pkg::out_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import cmnt_pkg::*;

  localparam int HALF = 16;

  out_t texel_q[$];

  // largest byte b with (2b-255)*sqrt(s) <= 255*c
  function automatic logic [CODE_W-1:0] bias_code(longint c, longint s);
    longint d;
    for (int b = 255; b > 0; b--) begin
      d = 2 * b - 255;
      if (d <= 0 && c >= 0) return b[CODE_W-1:0];
      if (d > 0 && c >= 0 && d * d * s <= 65025 * c * c) return b[CODE_W-1:0];
      if (d <= 0 && c < 0 && d * d * s >= 65025 * c * c) return b[CODE_W-1:0];
    end
    return '0;
  endfunction

  function automatic out_t unit_texel(in_t t);
    out_t r;
    longint i, j, x, y, z, s;
    i = t.column;
    j = t.row;
    case (t.face)
      FACE_PX: begin x = HALF;     y = HALF - j; z = HALF - i; end
      FACE_NX: begin x = -HALF;    y = HALF - j; z = i - HALF; end
      FACE_PY: begin x = i - HALF; y = HALF;     z = j - HALF; end
      FACE_NY: begin x = i - HALF; y = -HALF;    z = HALF - j; end
      FACE_PZ: begin x = i - HALF; y = HALF - j; z = HALF;     end
      FACE_NZ: begin x = HALF - i; y = HALF - j; z = -HALF;    end
      default: return '0;
    endcase
    s = x * x + y * y + z * z;
    r.red   = bias_code(x, s);
    r.green = bias_code(y, s);
    r.blue  = bias_code(z, s);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = texel_q.size();

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) texel_q.push_back(unit_texel(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (texel_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
        else begin
          want = texel_q.pop_front();
          if (out_data_i.red != want.red) report_mismatch("red", out_data_i.red, want.red);
          if (out_data_i.green != want.green)
            report_mismatch("green", out_data_i.green, want.green);
          if (out_data_i.blue != want.blue)
            report_mismatch("blue", out_data_i.blue, want.blue);
        end
      end
    end
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import cmnt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;

  // receiver behavior, set by the stimulus process
  bit          rx_random = 1'b1;
  bit          rx_hold = 1'b0;

  always #2 clk = ~clk;

  cube_map_normal_texel i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tb_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // one texel transfer; inputs move on the falling edge only
  task automatic send_texel(in_t t, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // receiver: random stall bursts, or a long hold-off, or always ready
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
        out_ready = 1'b1;
      end else if (rx_random && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        burst = $urandom_range(1, 12);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    in_t t;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corners and centers of every face code, the unused codes included
    for (int f = 0; f < 8; f++) begin
      t.face = f[FACE_W-1:0];
      t.column = (f % 2) ? 5'd31 : 5'd0;
      t.row = (f % 3) ? 5'd0 : 5'd31;
      send_texel(t, 1'b0);
      t.column = 5'd16;
      t.row = 5'd16;
      send_texel(t, 1'b0);
    end
    t = '{face: FACE_PZ, column: 5'd31, row: 5'd31};
    send_texel(t, 1'b0);
    t = '{face: FACE_NY, column: 5'd0, row: 5'd0};
    send_texel(t, 1'b0);

    // long receiver hold-off while texels keep coming, filling the pipe
    rx_hold = 1'b1;
    for (int n = 0; n < 60; n++) begin
      t.face = FACE_W'($urandom_range(0, 5));
      t.column = IDX_W'($urandom);
      t.row = IDX_W'($urandom);
      send_texel(t, 1'b0);
    end

    // random texels, mostly valid faces
    for (int n = 0; n < 640; n++) begin
      t.face = FACE_W'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                    : $urandom_range(0, 5));
      t.column = IDX_W'($urandom);
      t.row = IDX_W'($urandom);
      if (n >= 560) rx_random = 1'b0;
      send_texel(t, n < 560);
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("** cube_map_normal_texel: PASSED **");
    end else begin
      $display("** cube_map_normal_texel: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** cube_map_normal_texel: FAILED **");
    $finish;
  end
endmodule
